/* design/glyph_cache_tag_lookup_assert.svh */
// Assertion macros used by the glyph cache tag lookup datapath.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GLYPH_CACHE_TAG_LOOKUP_ASSERT_SVH
`define GLYPH_CACHE_TAG_LOOKUP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define GCTL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gctl assertion failed");

// Next-cycle implication, masked during reset.
`define GCTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gctl assertion failed");

`endif

/* design/gctl_pkg.sv */
// Shared types and constants for the glyph cache tag lookup.
// No dependencies; all files but gctl_ram use this package.
`timescale 1ns / 1ps

package gctl_pkg;

    localparam int GCTL_ENTRIES        = 512;
    localparam int GCTL_SUBPIXEL_STEPS = 4;

    localparam int CP_W   = 21;
    localparam int PX_W   = 8;
    localparam int PH_W   = 3;
    localparam int TAG_W  = 32;
    localparam int SLOT_W = 9;
    localparam int TAG_PH_W = 2;

    localparam int MIN_PIXEL_SIZE = 8;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic            req_type;
        logic [CP_W-1:0] code_point;
        logic [PX_W-1:0] pixel_size;
        logic            bold_flag;
        logic [PH_W-1:0] subpixel_phase;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot_index;
        logic              replaced;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic req_ready;
        logic accept;
        logic clear;
        logic rd_en;
        logic scan_inc;
        logic set_hit;
        logic alloc;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_valid;
        logic req_clear;
        logic fill_empty;
        logic tag_match;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

/* design/gctl_if.sv */
// Request and response channel interfaces of the glyph cache tag lookup.
// Depends on gctl_pkg for the beat payload types.
`timescale 1ns / 1ps

interface gctl_req_if;
    logic          valid;
    logic          ready;
    gctl_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gctl_rsp_if;
    logic          valid;
    logic          ready;
    gctl_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/gctl_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module gctl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/gctl_ctrl.sv */
// Sequencing state machine for the glyph cache tag lookup.
// Depends on gctl_pkg; drives gctl_datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps

module gctl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  gctl_pkg::status_t  status,
    output gctl_pkg::cmd_t     cmd
);

    import gctl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CMP   = 5'b00100,
        S_ALLOC = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.req_ready = 1'b1;
                if (status.req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.req_clear)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (status.fill_empty)
                    begin
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (status.tag_match)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = S_OUT;
                end
                else if (status.scan_last)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold the result until the output register is free
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/gctl_datapath.sv */
// Tag formation, tag RAM, scan pointer, fill count and output register.
// Depends on gctl_pkg, gctl_if and gctl_ram; takes commands from gctl_ctrl.
`timescale 1ns / 1ps
`include "glyph_cache_tag_lookup_assert.svh"

module gctl_datapath #(
    parameter int ENTRIES        = gctl_pkg::GCTL_ENTRIES,
    parameter int SUBPIXEL_STEPS = gctl_pkg::GCTL_SUBPIXEL_STEPS
) (
    input  logic              clk,
    input  logic              rst_n,
    gctl_req_if.sink          req,
    gctl_rsp_if.source        rsp,
    input  gctl_pkg::cmd_t    cmd,
    output gctl_pkg::status_t status
);

    import gctl_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int PH_MAX = (SUBPIXEL_STEPS - 1 > 3) ? 3 : SUBPIXEL_STEPS - 1;

    logic [TAG_W-1:0]    tag_reg;
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    scan_idx_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic                res_hit_reg;
    logic [IDX_W-1:0]    res_slot_reg;
    logic                res_replaced_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    rsp_t                out_data_reg;

    logic [TAG_W-1:0]    req_tag;
    logic [PX_W-1:0]     px_clamped;
    logic [TAG_PH_W-1:0] ph_clamped;
    logic                fill_room;
    logic [IDX_W-1:0]    alloc_slot;
    logic [TAG_W-1:0]    rd_data;

    // Pixel size raised to the minimum, phase limited to the top step
    always_comb
    begin
        px_clamped = (req.data.pixel_size < PX_W'(MIN_PIXEL_SIZE)) ?
                     PX_W'(MIN_PIXEL_SIZE) : req.data.pixel_size;
        ph_clamped = (req.data.subpixel_phase > PH_W'(PH_MAX)) ?
                     TAG_PH_W'(PH_MAX) : req.data.subpixel_phase[TAG_PH_W-1:0];
        req_tag    = {ph_clamped, req.data.bold_flag, px_clamped, req.data.code_point};
    end

    // Valid entries always form the prefix below the fill count
    assign fill_room  = (fill_reg != CNT_W'(ENTRIES));
    assign alloc_slot = fill_room ? fill_reg[IDX_W-1:0] : '0;

    gctl_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (cmd.alloc),
        .wr_addr (alloc_slot),
        .wr_data (tag_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    assign req.ready = cmd.req_ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        status.req_valid  = req.valid;
        status.req_clear  = (req.data.req_type == REQ_CLEAR);
        status.fill_empty = (fill_reg == '0);
        status.tag_match  = (rd_data == tag_reg);
        status.scan_last  = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == fill_reg);
        status.out_free   = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        if (cmd.accept)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end

        fill_next = fill_reg;
        if (cmd.clear)
        begin
            fill_next = '0;
        end
        else if (cmd.alloc && fill_room)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_idx_reg  <= scan_idx_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tag_reg <= req_tag;
        end
        if (cmd.clear)
        begin
            res_hit_reg      <= 1'b0;
            res_slot_reg     <= '0;
            res_replaced_reg <= 1'b0;
        end
        else if (cmd.set_hit)
        begin
            res_hit_reg      <= 1'b1;
            res_slot_reg     <= scan_idx_reg;
            res_replaced_reg <= 1'b0;
        end
        else if (cmd.alloc)
        begin
            res_hit_reg      <= 1'b0;
            res_slot_reg     <= alloc_slot;
            res_replaced_reg <= !fill_room;
        end
        if (cmd.load_out)
        begin
            out_data_reg.hit        <= res_hit_reg;
            out_data_reg.slot_index <= SLOT_W'(res_slot_reg);
            out_data_reg.replaced   <= res_replaced_reg;
        end
    end

    `GCTL_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CNT_W'(ENTRIES))
    `GCTL_ASSERT_IMP(a_hit_in_prefix, cmd.set_hit, CNT_W'(scan_idx_reg) < fill_reg)
    `GCTL_ASSERT_NEXT(a_clear_empties, cmd.clear, fill_reg == '0)
    `GCTL_ASSERT_NEXT(a_replace_when_full, cmd.alloc, res_replaced_reg == ($past(fill_reg) == CNT_W'(ENTRIES)))

endmodule

/* design/glyph_cache_tag_lookup.sv */
// Glyph cache tag lookup: fully associative tag store with a sequential tag scan.
// A lookup reads and then compares the stored tags one slot at a time, allocating a
// slot on a miss; a clear empties the store and goes straight to the output register.
// One item at a time: a new request is taken only in idle, after the last result has
// been loaded into the output register; a waiting result does not block the next beat.
// Reset (rst_n, asynchronous, active low) empties the store through the fill count.
`timescale 1ns / 1ps

module glyph_cache_tag_lookup #(
    parameter int ENTRIES        = gctl_pkg::GCTL_ENTRIES,
    parameter int SUBPIXEL_STEPS = gctl_pkg::GCTL_SUBPIXEL_STEPS
) (
    input  logic       clk,
    input  logic       rst_n,
    gctl_req_if.sink   req,
    gctl_rsp_if.source rsp
);

    import gctl_pkg::*;

    cmd_t    cmd;
    status_t status;

    gctl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    gctl_datapath #(
        .ENTRIES        (ENTRIES),
        .SUBPIXEL_STEPS (SUBPIXEL_STEPS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule

/* tb/sv/glyph_cache_tag_lookup_tb.sv */
// Self-checking bench for the glyph cache tag lookup: directed probes, then random lookups.
// Uses gctl_pkg for the beat types and gctl_if for the request and result channels.
`timescale 1ns / 1ps

module glyph_cache_tag_lookup_tb;
    import gctl_pkg::*;

    localparam int PHASE_CAP = (GCTL_SUBPIXEL_STEPS - 1 < (1 << TAG_PH_W) - 1) ?
                               GCTL_SUBPIXEL_STEPS - 1 : (1 << TAG_PH_W) - 1;
    localparam int NUM_DIRECTED  = 21;
    localparam int HISTORY_DEPTH = 16;
    localparam int HOLD_CYCLES   = 2500;
    localparam int QUIET_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 2 * GCTL_ENTRIES + 16;

    typedef struct packed {
        req_t rq;
        logic typed;
        rsp_t rs;
    } glyph_probe_t;

    // Typed results hold only where the answer is plain; the rest go to the predictor.
    localparam glyph_probe_t DIRECTED_PROBES [NUM_DIRECTED] = '{
        '{'{REQ_LOOKUP, 21'h000000, 8'd0,   1'b0, 3'd0}, 1'b1, '{1'b0, 9'd0, 1'b0}},
        '{'{REQ_LOOKUP, 21'h000000, 8'd8,   1'b0, 3'd0}, 1'b1, '{1'b1, 9'd0, 1'b0}},
        '{'{REQ_LOOKUP, 21'h000000, 8'd7,   1'b0, 3'd0}, 1'b1, '{1'b1, 9'd0, 1'b0}},
        '{'{REQ_LOOKUP, 21'h1FFFFF, 8'd255, 1'b1, 3'd7}, 1'b1, '{1'b0, 9'd1, 1'b0}},
        '{'{REQ_LOOKUP, 21'h1FFFFF, 8'd255, 1'b1, 3'd3}, 1'b1, '{1'b1, 9'd1, 1'b0}},
        '{'{REQ_LOOKUP, 21'h1FFFFF, 8'd255, 1'b1, 3'd4}, 1'b1, '{1'b1, 9'd1, 1'b0}},
        '{'{REQ_LOOKUP, 21'h10FFFF, 8'd9,   1'b0, 3'd2}, 1'b1, '{1'b0, 9'd2, 1'b0}},
        '{'{REQ_LOOKUP, 21'h10FFFF, 8'd9,   1'b0, 3'd1}, 1'b0, '0},
        '{'{REQ_LOOKUP, 21'h10FFFF, 8'd9,   1'b1, 3'd1}, 1'b0, '0},
        '{'{REQ_LOOKUP, 21'h10FFFF, 8'd8,   1'b1, 3'd1}, 1'b0, '0},
        '{'{REQ_LOOKUP, 21'h110000, 8'd128, 1'b0, 3'd5}, 1'b0, '0},
        '{'{REQ_LOOKUP, 21'h0AAAAA, 8'h55,  1'b1, 3'd2}, 1'b0, '0},
        '{'{REQ_LOOKUP, 21'h155555, 8'hAA,  1'b0, 3'd1}, 1'b0, '0},
        '{'{REQ_LOOKUP, 21'h10FFFF, 8'd9,   1'b0, 3'd1}, 1'b0, '0},
        '{'{REQ_CLEAR,  21'h1FFFFF, 8'd255, 1'b1, 3'd7}, 1'b1, '{1'b0, 9'd0, 1'b0}},
        '{'{REQ_LOOKUP, 21'h1FFFFF, 8'd255, 1'b1, 3'd7}, 1'b1, '{1'b0, 9'd0, 1'b0}},
        '{'{REQ_CLEAR,  21'h000000, 8'd0,   1'b0, 3'd0}, 1'b1, '{1'b0, 9'd0, 1'b0}},
        '{'{REQ_CLEAR,  21'h000000, 8'd0,   1'b0, 3'd0}, 1'b1, '{1'b0, 9'd0, 1'b0}},
        '{'{REQ_LOOKUP, 21'h000041, 8'd16,  1'b0, 3'd0}, 1'b1, '{1'b0, 9'd0, 1'b0}},
        '{'{REQ_LOOKUP, 21'h000041, 8'd16,  1'b0, 3'd3}, 1'b0, '0},
        '{'{REQ_LOOKUP, 21'h000041, 8'd16,  1'b0, 3'd6}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    gctl_req_if req_ch ();
    gctl_rsp_if rsp_ch ();

    glyph_cache_tag_lookup uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the tag store
    logic             shadow_valid [GCTL_ENTRIES];
    logic [TAG_W-1:0] shadow_tag   [GCTL_ENTRIES];
    int               stored_count;

    rsp_t expected_lookups [$];
    req_t recent_lookups [$];
    int   mismatch_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_requested;

    function automatic logic [TAG_W-1:0] glyph_tag(req_t r);
        logic [PX_W-1:0] px;
        logic [PH_W-1:0] ph;
        px = (r.pixel_size < MIN_PIXEL_SIZE) ? PX_W'(MIN_PIXEL_SIZE) : r.pixel_size;
        ph = (r.subpixel_phase > PHASE_CAP) ? PH_W'(PHASE_CAP) : r.subpixel_phase;
        return {ph[TAG_PH_W-1:0], r.bold_flag, px, r.code_point};
    endfunction

    function automatic rsp_t predict_slot(req_t r);
        rsp_t             res;
        logic [TAG_W-1:0] tag;
        int               i;
        int               slot;
        res = '0;
        if (r.req_type == REQ_CLEAR)
        begin
            foreach (shadow_valid[j])
                shadow_valid[j] = 1'b0;
            stored_count = 0;
            return res;
        end
        tag = glyph_tag(r);
        for (i = 0; i < GCTL_ENTRIES; i++)
        begin
            if (shadow_valid[i] && shadow_tag[i] == tag)
            begin
                res.hit        = 1'b1;
                res.slot_index = SLOT_W'(i);
                return res;
            end
        end
        // Lowest free slot, else overwrite slot zero
        slot         = 0;
        res.replaced = 1'b1;
        for (i = 0; i < GCTL_ENTRIES; i++)
        begin
            if (!shadow_valid[i])
            begin
                slot         = i;
                res.replaced = 1'b0;
                break;
            end
        end
        if (!res.replaced)
            stored_count++;
        shadow_valid[slot] = 1'b1;
        shadow_tag[slot]   = tag;
        res.slot_index     = SLOT_W'(slot);
        return res;
    endfunction

    function automatic req_t fresh_glyph_req();
        req_t r;
        r.req_type       = REQ_LOOKUP;
        // A narrow code point range now and then provokes collisions
        r.code_point     = ($urandom_range(3) == 0) ? CP_W'($urandom_range(63)) : CP_W'($urandom);
        r.pixel_size     = ($urandom_range(3) == 0) ? PX_W'($urandom_range(MIN_PIXEL_SIZE)) :
                                                      PX_W'($urandom);
        r.bold_flag      = 1'($urandom);
        r.subpixel_phase = PH_W'($urandom);
        return r;
    endfunction

    function automatic req_t clear_req();
        req_t r;
        r          = fresh_glyph_req();
        r.req_type = REQ_CLEAR;
        return r;
    endfunction

    // Same tag under a different spelling, occasionally one code point bit off
    function automatic req_t alias_of(req_t r);
        req_t a;
        a = r;
        if (a.pixel_size <= MIN_PIXEL_SIZE)
            a.pixel_size = PX_W'($urandom_range(MIN_PIXEL_SIZE));
        if (a.subpixel_phase >= PHASE_CAP)
            a.subpixel_phase = PH_W'($urandom_range((1 << PH_W) - 1, PHASE_CAP));
        if ($urandom_range(7) == 0)
            a.code_point ^= CP_W'(1) << $urandom_range(CP_W - 1);
        return a;
    endfunction

    function automatic req_t pick_lookup(int reuse_pct);
        if (recent_lookups.size() > 0 && $urandom_range(99) < reuse_pct)
            return alias_of(recent_lookups[$urandom_range(recent_lookups.size() - 1)]);
        return fresh_glyph_req();
    endfunction

    task automatic send_beat(req_t r, logic typed, rsp_t typed_rsp);
        rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = predict_slot(r);
        expected_lookups.push_back(typed ? typed_rsp : predicted);
        if (r.req_type == REQ_LOOKUP)
        begin
            recent_lookups.push_back(r);
            if (recent_lookups.size() > HISTORY_DEPTH)
                void'(recent_lookups.pop_front());
        end
    endtask

    task automatic run_sessions(int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 8)
                send_beat(clear_req(), 1'b0, '0);
            else
                send_beat(pick_lookup(45), 1'b0, '0);
        end
    endtask

    // Fill every slot, then mix repeats and new glyphs so that misses overwrite slot zero
    task automatic fill_store();
        send_beat(clear_req(), 1'b0, '0);
        while (stored_count < GCTL_ENTRIES)
            send_beat(pick_lookup(0), 1'b0, '0);
        repeat (16)
            send_beat(pick_lookup(50), 1'b0, '0);
    endtask

    task automatic check_result(rsp_t got);
        rsp_t want;
        if (expected_lookups.size() == 0)
        begin
            $error("unexpected result beat: hit %0d slot_index %0d replaced %0d",
                   got.hit, got.slot_index, got.replaced);
            mismatch_count++;
            return;
        end
        want = expected_lookups.pop_front();
        if (got.hit !== want.hit)
        begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            mismatch_count++;
        end
        if (got.slot_index !== want.slot_index)
        begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
            mismatch_count++;
        end
        if (got.replaced !== want.replaced)
        begin
            $error("replaced: expected %0d, got %0d", want.replaced, got.replaced);
            mismatch_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                check_result(rsp_ch.data);
            if (hold_requested)
            begin
                hold_requested = 1'b0;
                hold_left      = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Give up once nothing has moved on either channel for too long
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("** glyph_cache_tag_lookup: FAILED **");
        $finish;
    end

    initial
    begin
        foreach (shadow_valid[i])
            shadow_valid[i] = 1'b0;
        stored_count   = 0;
        mismatch_count = 0;
        hold_requested = 1'b0;
        send_idle_pct  = 18;
        recv_idle_pct  = 48;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (DIRECTED_PROBES[i])
            send_beat(DIRECTED_PROBES[i].rq, DIRECTED_PROBES[i].typed, DIRECTED_PROBES[i].rs);
        run_sessions(12);

        send_idle_pct = 48;
        recv_idle_pct = 18;
        fill_store();

        // Back-to-back beats against a stalled result side
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_requested = 1'b1;
        run_sessions(18);
        req_ch.valid <= 1'b0;

        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("** glyph_cache_tag_lookup: PASSED **");
        else
            $display("** glyph_cache_tag_lookup: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/gctl_pkg.sv
design/gctl_if.sv
design/gctl_ram.sv
design/gctl_ctrl.sv
design/gctl_datapath.sv
design/glyph_cache_tag_lookup.sv
tb/sv/glyph_cache_tag_lookup_tb.sv
